// File: src/tre_pkg.sv
// ----------------------------------------------------------------------------
// tre_pkg
// shared types and constants of the tcp retransmission timeout estimator
// ----------------------------------------------------------------------------
package tre_pkg;

  localparam int unsigned RtoW    = 18;
  localparam int unsigned RttW    = 22;
  localparam int unsigned RetryW  = 5;
  localparam int unsigned Q3W     = 26;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [RetryW-1:0] RetryCap = 5'd31;

  // reset values
  localparam logic [RtoW-1:0]   MinRtoRst     = 18'd1000;
  localparam logic [RtoW-1:0]   MaxRtoRst     = 18'd240000;
  localparam logic [RetryW-1:0] MaxRetriesRst = 5'd12;
  localparam logic [Q3W-1:0]    SrttRst       = 26'd0;
  localparam logic [Q3W-1:0]    RttvarRst     = 26'd6000;
  localparam logic [RtoW-1:0]   RtoRst        = 18'd3000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_RTO     = 2'd0,
    CFG_MAX_RTO     = 2'd1,
    CFG_MAX_RETRIES = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_EXPIRE  = 2'd1,
    REQ_RESTART = 2'd2
  } req_e;

  typedef struct packed {
    logic [RtoW-1:0]   min_rto;
    logic [RtoW-1:0]   max_rto;
    logic [RetryW-1:0] max_retries;
  } cfg_t;

  typedef struct packed {
    logic [Q3W-1:0]    srtt_q3;
    logic [Q3W-1:0]    rttvar_q3;
    logic [RtoW-1:0]   rto;
    logic [RetryW-1:0] retries;
  } est_t;

endpackage

// File: src/tre_cfg_regs.sv
// ----------------------------------------------------------------------------
// tre_cfg_regs
// configuration registers: timeout clamps and retry limit
// ----------------------------------------------------------------------------
module tre_cfg_regs import tre_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RtoW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_RTO:     cfg_d.min_rto     = cfg_data_i;
        CFG_MAX_RTO:     cfg_d.max_rto     = cfg_data_i;
        CFG_MAX_RETRIES: cfg_d.max_retries = cfg_data_i[RetryW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_rto     <= MinRtoRst;
      cfg_q.max_rto     <= MaxRtoRst;
      cfg_q.max_retries <= MaxRetriesRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/tre_update.sv
// ----------------------------------------------------------------------------
// tre_update
// next estimator state and abort flag for one event
// ----------------------------------------------------------------------------
module tre_update import tre_pkg::*; (
  input  cfg_t            cfg_i,
  input  est_t            est_i,
  input  logic [1:0]      req_type_i,
  input  logic [RttW-1:0] rtt_ms_i,
  output est_t            est_o,
  output logic            abort_o
);

  logic signed [27:0] err;
  logic        [27:0] mag;
  logic signed [27:0] s_sum;
  logic signed [28:0] v_diff;
  logic signed [28:0] v_sum;
  logic        [Q3W-1:0] s_new;
  logic        [Q3W-1:0] v_new;
  logic        [28:0] t_sum;
  logic        [25:0] t_ms;
  logic        [RtoW-1:0] t_clamp;
  logic        [RetryW-1:0] retry_inc;
  logic        [RtoW:0] dbl;
  logic        [RtoW-1:0] dbl_cap;

  // mean and deviation update, shifts are floor divides by 8
  always_comb begin
    err    = $signed({3'b000, rtt_ms_i, 3'b000}) - $signed({2'b00, est_i.srtt_q3});
    mag    = err[27] ? 28'(-err) : 28'(err);
    s_sum  = $signed({2'b00, est_i.srtt_q3}) + (err >>> 3);
    s_new  = s_sum[Q3W-1:0];
    v_diff = $signed({1'b0, mag}) - $signed({3'b000, est_i.rttvar_q3});
    v_sum  = $signed({3'b000, est_i.rttvar_q3}) + (v_diff >>> 3);
    v_new  = v_sum[Q3W-1:0];
    t_sum  = {3'b000, s_new} + {1'b0, v_new, 2'b00};
    t_ms   = t_sum[28:3];
    if (t_ms > {8'd0, cfg_i.max_rto}) begin
      t_clamp = cfg_i.max_rto;
    end else if (t_ms < {8'd0, cfg_i.min_rto}) begin
      t_clamp = cfg_i.min_rto;
    end else begin
      t_clamp = t_ms[RtoW-1:0];
    end
  end

  // back-off path
  always_comb begin
    retry_inc = (est_i.retries != RetryCap) ? est_i.retries + 1'b1 : est_i.retries;
    dbl       = {est_i.rto, 1'b0};
    dbl_cap   = (dbl > {1'b0, cfg_i.max_rto}) ? cfg_i.max_rto : dbl[RtoW-1:0];
  end

  always_comb begin
    est_o   = est_i;
    abort_o = 1'b0;
    unique case (req_type_i)
      REQ_SAMPLE: begin
        est_o.srtt_q3   = s_new;
        est_o.rttvar_q3 = v_new;
        est_o.rto       = t_clamp;
      end
      REQ_EXPIRE: begin
        est_o.retries = retry_inc;
        if (retry_inc > cfg_i.max_retries) begin
          abort_o = 1'b1;
        end else begin
          est_o.rto = dbl_cap;
        end
      end
      REQ_RESTART: begin
        est_o.retries = '0;
      end
      default: begin
        est_o = est_i;
      end
    endcase
  end

endmodule

// File: src/tcp_rto_estimator.sv
// ----------------------------------------------------------------------------
// tcp_rto_estimator
// retransmission timeout estimator for one tcp connection
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o) carries one event item: an rtt
//   sample, a timer expiry or a timer restart. every item yields exactly one
//   result item on the output channel (out_valid_o / out_ready_i) with the
//   timeout, smoothed rtt, retry count and abort flag after that event.
//   an item accepted into the input register is evaluated against the
//   estimator state and then lands in the result register, where it is
//   visible until taken; one item per cycle sustained while the receiver
//   does not stall. the rate is set by the single evaluate stage, whose
//   state update is combinational and commits as the item moves on, so
//   events can follow each other directly.
//   when the receiver stalls, the result register holds; the input register
//   still takes one more item, then in_ready_o drops until the result moves.
//   reset clears both registers to empty and loads the default clamps
//   (1000 ms / 240000 ms, 12 retries) and the initial estimator state
//   (srtt 0, rttvar 750 ms, timeout 3000 ms, no retries).
//   configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
//   the next edge and are meant to happen while the block is idle.
// ----------------------------------------------------------------------------
module tcp_rto_estimator import tre_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RtoW-1:0]    cfg_data_i,
  // event items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [RttW-1:0]    rtt_ms_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [RtoW-1:0]    rto_ms_o,
  output logic [RttW-1:0]    srtt_ms_o,
  output logic [RetryW-1:0]  retries_o,
  output logic               abort_o
);

  cfg_t cfg;

  // input register
  logic            s1_valid_q, s1_valid_d;
  logic [1:0]      s1_req_q;
  logic [RttW-1:0] s1_rtt_q;

  // estimator state
  est_t est_q, est_d, est_nxt;
  logic abort_nxt;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [RtoW-1:0]   out_rto_q;
  logic [RttW-1:0]   out_srtt_q;
  logic [RetryW-1:0] out_retries_q;
  logic              out_abort_q;

  logic advance;
  logic load_in;

  tre_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tre_update u_update (
    .cfg_i      (cfg),
    .est_i      (est_q),
    .req_type_i (s1_req_q),
    .rtt_ms_i   (s1_rtt_q),
    .est_o      (est_nxt),
    .abort_o    (abort_nxt)
  );

  // result register free or being drained this cycle
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign load_in    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    est_d       = est_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
    if (advance) begin
      out_valid_d = s1_valid_q;
      // state commits only when the event moves into the result register
      if (s1_valid_q) begin
        est_d = est_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      est_q.srtt_q3   <= SrttRst;
      est_q.rttvar_q3 <= RttvarRst;
      est_q.rto       <= RtoRst;
      est_q.retries   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      est_q       <= est_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_in) begin
      s1_req_q <= req_type_i;
      s1_rtt_q <= rtt_ms_i;
    end
    if (advance && s1_valid_q) begin
      out_rto_q     <= est_nxt.rto;
      out_srtt_q    <= est_nxt.srtt_q3[RttW+2:3];
      out_retries_q <= est_nxt.retries;
      out_abort_q   <= abort_nxt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rto_ms_o    = out_rto_q;
  assign srtt_ms_o   = out_srtt_q;
  assign retries_o   = out_retries_q;
  assign abort_o     = out_abort_q;

  // abort only when the reported count is past the limit
  a_abort_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && abort_o |-> retries_o > cfg.max_retries)
    else $error("abort flagged with retry count within limit");

  // input side only blocks behind a full input register and a stalled result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a stalled result");

  // state held while the evaluate stage cannot move
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(est_q))
    else $error("estimator state changed during output stall");

  // mean and deviation stay below 2^25 ms/8
  a_q3_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !est_q.srtt_q3[Q3W-1] && !est_q.rttvar_q3[Q3W-1])
    else $error("smoothed rtt or variance out of range");

endmodule

// File: tb/sv/tre_result_checker.sv
// ----------------------------------------------------------------------------
// tre_result_checker
// watches both item channels and the register port of the timeout estimator,
// predicts each result from its own copy of the estimator state and compares
// ----------------------------------------------------------------------------
module tre_result_checker import tre_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RtoW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         req_type_i,
  input  logic [RttW-1:0]    rtt_ms_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [RtoW-1:0]    rto_ms_i,
  input  logic [RttW-1:0]    srtt_ms_i,
  input  logic [RetryW-1:0]  retries_i,
  input  logic               abort_i,
  output int                 pending_o,
  output int                 fail_cnt_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [RtoW-1:0]   rto;
    logic [RttW-1:0]   srtt;
    logic [RetryW-1:0] retries;
    logic              abort;
  } timeout_result_t;

  cfg_t            clamps;
  est_t            est;
  timeout_result_t timeout_q[$];
  int              fails;

  // one event applied to the estimator copy, returns the result it causes
  function automatic timeout_result_t apply_event(input logic [1:0] kind,
                                                  input logic [RttW-1:0] rtt);
    timeout_result_t res;
    longint          err, mag, s, v, t;
    logic [RtoW:0]   dbl;
    res.abort = 1'b0;
    case (req_e'(kind))
      REQ_SAMPLE: begin
        s   = longint'(est.srtt_q3);
        v   = longint'(est.rttvar_q3);
        err = (longint'(rtt) << 3) - s;
        mag = (err < 0) ? -err : err;
        // arithmetic shift of a signed value floors toward minus infinity
        s   = s + (err >>> 3);
        v   = v + ((mag - v) >>> 3);
        est.srtt_q3   = s[Q3W-1:0];
        est.rttvar_q3 = v[Q3W-1:0];
        t = (longint'(est.srtt_q3) + 4 * longint'(est.rttvar_q3)) >>> 3;
        if (t > longint'(clamps.max_rto)) begin
          t = longint'(clamps.max_rto);
        end else if (t < longint'(clamps.min_rto)) begin
          t = longint'(clamps.min_rto);
        end
        est.rto = t[RtoW-1:0];
      end
      REQ_EXPIRE: begin
        if (est.retries != RetryCap) begin
          est.retries = est.retries + 1'b1;
        end
        if (est.retries > clamps.max_retries) begin
          res.abort = 1'b1;
        end else begin
          dbl = {est.rto, 1'b0};
          if (dbl > {1'b0, clamps.max_rto}) begin
            dbl = {1'b0, clamps.max_rto};
          end
          est.rto = dbl[RtoW-1:0];
        end
      end
      REQ_RESTART: begin
        est.retries = '0;
      end
      default: begin
      end
    endcase
    res.rto     = est.rto;
    res.srtt    = est.srtt_q3[RttW+2:3];
    res.retries = est.retries;
    return res;
  endfunction

  function automatic int field_bad(input string tag, input logic [31:0] want,
                                   input logic [31:0] got);
    if (got === want) return 0;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    timeout_result_t want;
    int              bad;
    if (!rst_ni) begin
      clamps.min_rto     = MinRtoRst;
      clamps.max_rto     = MaxRtoRst;
      clamps.max_retries = MaxRetriesRst;
      est.srtt_q3        = SrttRst;
      est.rttvar_q3      = RttvarRst;
      est.rto            = RtoRst;
      est.retries        = '0;
      timeout_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MIN_RTO:     clamps.min_rto = cfg_data_i;
          CFG_MAX_RTO:     clamps.max_rto = cfg_data_i;
          CFG_MAX_RETRIES: clamps.max_retries = cfg_data_i[RetryW-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        timeout_q.push_back(apply_event(req_type_i, rtt_ms_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (timeout_q.size() == 0) begin
          $display("%0t: result with no item pending, expected none, got rto %0d srtt %0d",
                   $time, rto_ms_i, srtt_ms_i);
          fails++;
        end else begin
          want = timeout_q.pop_front();
          bad  = field_bad("rto_ms", 32'(want.rto), 32'(rto_ms_i))
               + field_bad("srtt_ms", 32'(want.srtt), 32'(srtt_ms_i))
               + field_bad("retries", 32'(want.retries), 32'(retries_i))
               + field_bad("abort", 32'(want.abort), 32'(abort_i));
          if (bad != 0) fails++;
        end
      end
    end
    pending_o  <= timeout_q.size();
    fail_cnt_o <= fails;
  end

endmodule

// File: tb/sv/tb_tcp_rto_estimator.sv
// ----------------------------------------------------------------------------
// tb_tcp_rto_estimator
// drives rtt samples, timer expiries and restarts into the timeout estimator
// under changing clamp and retry settings, with random stalls on both sides;
// a separate checker predicts and compares every result item
// ----------------------------------------------------------------------------
module tb_tcp_rto_estimator;

  timeunit 1ns;
  timeprecision 1ps;

  import tre_pkg::*;

  localparam int          ItemTarget = 1700;
  localparam int          CycleLimit = 200000;
  localparam int          HoldCycles = 120;
  localparam int unsigned RttTop     = 32'h3F_FFFF;
  localparam int unsigned RtoTop     = 32'h3_FFFF;

  // codes the package leaves unnamed: event kind 3 and register index 3
  localparam req_e      ReqUnused = req_e'(2'd3);
  localparam cfg_idx_e  CfgUnused = cfg_idx_e'(2'd3);

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [RtoW-1:0]    cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         req_type_i;
  logic [RttW-1:0]    rtt_ms_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [RtoW-1:0]    rto_ms_o;
  logic [RttW-1:0]    srtt_ms_o;
  logic [RetryW-1:0]  retries_o;
  logic               abort_o;

  int pending;
  int fail_cnt;
  int sent_cnt;
  int cyc_cnt;

  // idling switches, flipped per phase; both off in the last phase
  bit gap_on;
  bit stall_on;
  // one long receiver hold-off, served by the receiver process
  bit hold_req;

  always #5 clk_i = ~clk_i;

  tcp_rto_estimator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .rtt_ms_i    (rtt_ms_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rto_ms_o    (rto_ms_o),
    .srtt_ms_o   (srtt_ms_o),
    .retries_o   (retries_o),
    .abort_o     (abort_o)
  );

  tre_result_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .req_type_i  (req_type_i),
    .rtt_ms_i    (rtt_ms_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .rto_ms_i    (rto_ms_o),
    .srtt_ms_i   (srtt_ms_o),
    .retries_i   (retries_o),
    .abort_i     (abort_o),
    .pending_o   (pending),
    .fail_cnt_o  (fail_cnt)
  );

  // cycle budget for the whole run, sized far above the slowest correct run
  initial begin
    cyc_cnt = 0;
    while (cyc_cnt < CycleLimit) begin
      @(posedge clk_i);
      cyc_cnt++;
    end
    $display("timeout after %0d cycles", cyc_cnt);
    $display("tb_tcp_rto_estimator failed");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int burst;
    int hold_left;
    burst       = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready_i <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        // this cycle counts as the first of the burst
        burst = $urandom_range(1, 8) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // offer one item, hold it until accepted; returns at the next falling edge
  task automatic send_item(input req_e kind, input logic [RttW-1:0] rtt);
    if (gap_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    rtt_ms_i   <= rtt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    sent_cnt++;
  endtask

  // stop offering and wait for every result to come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // covers the two register stages, plus margin
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [RtoW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  // rtt values over several scales, with both ends of the field
  function automatic logic [RttW-1:0] pick_rtt();
    case ($urandom_range(0, 7))
      0:       return RttW'($urandom_range(0, 200));
      1, 2:    return RttW'($urandom_range(0, 5000));
      3:       return RttW'($urandom_range(0, 100000));
      4:       return RttW'($urandom_range(0, RttTop));
      5:       return RttW'(RttTop);
      6:       return '0;
      default: return RttW'($urandom_range(20, 800));
    endcase
  endfunction

  // new clamps and retry limit; the block must be idle first
  task automatic new_settings();
    logic [RtoW-1:0]   lo;
    logic [RtoW-1:0]   hi;
    logic [RetryW-1:0] lim;
    drain();
    case ($urandom_range(0, 5))
      0:       lo = '0;
      1:       lo = RtoW'(1);
      2:       lo = RtoW'(RtoTop);
      3:       lo = RtoW'($urandom_range(0, RtoTop));
      default: lo = RtoW'($urandom_range(1, 3000));
    endcase
    case ($urandom_range(0, 5))
      0:       hi = RtoW'(1);
      1:       hi = RtoW'(RtoTop);
      2:       hi = RtoW'($urandom_range(1, RtoTop));
      default: hi = RtoW'($urandom_range(3000, 250000));
    endcase
    case ($urandom_range(0, 4))
      0:       lim = '0;
      1:       lim = RetryW'(30);
      2:       lim = RetryW'(31);
      default: lim = RetryW'($urandom_range(0, 31));
    endcase
    write_reg(CFG_MIN_RTO, lo);
    write_reg(CFG_MAX_RTO, hi);
    // upper data bits are don't-care for the retry limit, so keep them noisy
    write_reg(CFG_MAX_RETRIES, {13'($urandom_range(0, 8191)), lim});
    if ($urandom_range(0, 7) == 0) begin
      // unmapped index, must leave everything alone
      write_reg(CfgUnused, RtoW'($urandom));
    end
  endtask

  // one random stretch of traffic: mostly realistic sequences, some noise
  task automatic random_burst();
    int          n;
    int unsigned base;
    int unsigned v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // steady path with jitter around a base rtt
        base = pick_rtt();
        n    = $urandom_range(1, 12);
        repeat (n) begin
          v = base + $urandom_range(0, base / 4 + 1);
          if (v > RttTop) v = RttTop;
          if ($urandom_range(0, 7) == 0) v = pick_rtt();
          send_item(REQ_SAMPLE, RttW'(v));
        end
      end
      4, 5, 6: begin
        // back-off run, long enough at times to hit the retry ceiling
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 34) : $urandom_range(1, 8);
        repeat (n) send_item(REQ_EXPIRE, RttW'($urandom));
        if ($urandom_range(0, 3) != 0) send_item(REQ_RESTART, RttW'($urandom));
      end
      7: send_item(REQ_RESTART, RttW'($urandom));
      8: send_item(ReqUnused, RttW'($urandom));
      default: send_item(req_e'($urandom_range(0, 3)), pick_rtt());
    endcase
  endtask

  initial begin
    int phase;
    int phase_end;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_MIN_RTO;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    req_type_i = REQ_SAMPLE;
    rtt_ms_i   = '0;
    rst_ni     = 1'b0;
    gap_on     = 1'b0;
    stall_on   = 1'b0;
    hold_req   = 1'b0;
    sent_cnt   = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: default clamps, field extremes and every event kind
    send_item(REQ_SAMPLE, '0);
    send_item(REQ_SAMPLE, RttW'(RttTop));
    send_item(REQ_SAMPLE, RttW'(RttTop));
    send_item(REQ_SAMPLE, RttW'(120));
    send_item(REQ_EXPIRE, RttW'(RttTop));
    send_item(REQ_EXPIRE, '0);
    send_item(REQ_RESTART, RttW'($urandom));
    // unused kind reports state unchanged
    send_item(ReqUnused, RttW'($urandom));
    send_item(REQ_SAMPLE, RttW'(1));

    // zero minimum, widest maximum, no retries allowed
    drain();
    write_reg(CFG_MIN_RTO, '0);
    write_reg(CFG_MAX_RTO, RtoW'(RtoTop));
    write_reg(CFG_MAX_RETRIES, '0);
    send_item(REQ_EXPIRE, '0);
    // abort again while still past the limit
    send_item(REQ_EXPIRE, '0);
    send_item(REQ_RESTART, '0);
    send_item(REQ_SAMPLE, '0);
    send_item(REQ_SAMPLE, '0);
    send_item(REQ_SAMPLE, '0);

    // maximum lowered under the current timeout, then a back-off
    drain();
    write_reg(CFG_MAX_RTO, RtoW'(500));
    write_reg(CFG_MAX_RETRIES, RetryW'(30));
    send_item(REQ_SAMPLE, RttW'(RttTop));
    send_item(REQ_EXPIRE, '0);

    // crossed clamps: minimum above maximum
    drain();
    write_reg(CFG_MIN_RTO, RtoW'(200000));
    write_reg(CFG_MAX_RTO, RtoW'(100));
    send_item(REQ_SAMPLE, RttW'(RttTop));
    send_item(REQ_SAMPLE, '0);
    send_item(REQ_EXPIRE, '0);
    send_item(REQ_RESTART, '0);

    // random phases, each under fresh settings
    sent_cnt = 0;
    phase    = 0;
    while (sent_cnt < ItemTarget) begin
      new_settings();
      if (sent_cnt > ItemTarget - 250) begin
        gap_on   = 1'b0;
        stall_on = 1'b0;
      end else begin
        gap_on   = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      // mid-run, let the receiver sit still so the input side backs up
      if (phase == 3) hold_req = 1'b1;
      phase_end = sent_cnt + $urandom_range(60, 160);
      while (sent_cnt < phase_end && sent_cnt < ItemTarget) random_burst();
      phase++;
    end

    drain();
    if (fail_cnt == 0) begin
      $display("tb_tcp_rto_estimator passed");
    end else begin
      $display("tb_tcp_rto_estimator failed");
    end
    $finish;
  end

endmodule
